// File: rtl/fme_pkg.sv
// Shared types, codes and constants of the fuzzy membership evaluator.
`timescale 1ns / 1ps

package fme_pkg;

   localparam int SAMPLE_WIDTH     = 16;
   localparam int MEMBER_FRAC_BITS = 15;
   localparam int COORD_WIDTH      = 16;
   localparam int MEMBER_WIDTH     = 16;
   localparam int POINT_COUNT      = 4;
   localparam int CSR_INDEX_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH   = 32;
   // One quotient bit per division cell.
   localparam int DIV_STEPS        = MEMBER_WIDTH;

   localparam logic [MEMBER_WIDTH-1:0] MEMBER_ONE =
      MEMBER_WIDTH'(1) << MEMBER_FRAC_BITS;

   typedef enum logic [2:0] {
      SHAPE_TRIANGLE  = 3'd0,
      SHAPE_RAMP      = 3'd1,
      SHAPE_TRAPEZOID = 3'd2,
      SHAPE_RECTANGLE = 3'd3,
      SHAPE_SINGLETON = 3'd4
   } shape_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_ORDER = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_SHAPE        = 3'd0,
      CSR_POINT_FIRST  = 3'd1,
      CSR_POINT_SECOND = 3'd2,
      CSR_POINT_THIRD  = 3'd3,
      CSR_POINT_FOURTH = 3'd4,
      CSR_TOLERANCE    = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] x;
      logic [MEMBER_WIDTH-1:0]       y;
   } point_type;

   // Data that rides alongside the division without being touched by it.
   typedef struct packed {
      logic [MEMBER_WIDTH-1:0] base;
      logic                    neg;
      status_type              status;
      logic                    use_tol;
   } side_type;

   // Output of the decode stage.
   typedef struct packed {
      logic                          valid;
      logic signed [MEMBER_WIDTH:0]  dy;
      logic [COORD_WIDTH-1:0]        dv;
      logic [COORD_WIDTH-1:0]        den;
      side_type                      side;
   } front_type;

   // One lane of the division chain: partial remainder and the numerator
   // word that shifts out while quotient bits shift in.
   typedef struct packed {
      logic                    valid;
      logic [COORD_WIDTH-1:0]  part;
      logic [MEMBER_WIDTH-1:0] nq;
      logic [COORD_WIDTH-1:0]  den;
      side_type                side;
   } lane_type;

endpackage

// File: rtl/fme_front.sv
// Decode stage: picks the segment or flat value for the sample and registers it.
`timescale 1ns / 1ps

module fme_front import fme_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic signed [SAMPLE_WIDTH-1:0] sample,
   input  logic [2:0]                    shape,
   input  point_type [POINT_COUNT-1:0]   points,
   output front_type                     front
);

   front_type front_ff;
   front_type front_in;

   logic signed [COORD_WIDTH-1:0] x0, x1, x2, x3;
   logic                          seg_en;
   logic [1:0]                    sel_a;
   logic [1:0]                    sel_b;
   logic signed [COORD_WIDTH:0]   dx_w;
   logic signed [COORD_WIDTH:0]   dv_w;
   logic signed [MEMBER_WIDTH:0]  dy_w;
   logic [MEMBER_WIDTH-1:0]       flat;
   status_type                    status;
   logic                          use_tol;

   assign x0 = points[0].x;
   assign x1 = points[1].x;
   assign x2 = points[2].x;
   assign x3 = points[3].x;

   always_comb begin
      seg_en  = 1'b0;
      sel_a   = 2'd0;
      sel_b   = 2'd1;
      flat    = '0;
      status  = ST_OK;
      use_tol = 1'b1;
      case (shape)
         SHAPE_TRIANGLE: begin
            if (sample <= x0) begin
               flat = points[0].y;
            end else if (sample >= x2) begin
               flat = points[2].y;
            end else if (sample <= x1) begin
               if (x1 <= x0) status = ST_ORDER;
               else seg_en = 1'b1;
            end else begin
               sel_a = 2'd1;
               sel_b = 2'd2;
               if (x2 <= x1) status = ST_ORDER;
               else seg_en = 1'b1;
            end
         end
         SHAPE_RAMP: begin
            if (sample <= x0) flat = points[0].y;
            else if (sample >= x1) flat = points[1].y;
            else seg_en = 1'b1;
         end
         SHAPE_TRAPEZOID: begin
            if (sample <= x0) begin
               flat = points[0].y;
            end else if (sample >= x3) begin
               flat = points[3].y;
            end else if (sample <= x1) begin
               if (x1 <= x0) status = ST_ORDER;
               else seg_en = 1'b1;
            end else if (sample <= x2) begin
               flat = points[1].y;
            end else begin
               sel_a = 2'd2;
               sel_b = 2'd3;
               if (x3 <= x2) status = ST_ORDER;
               else seg_en = 1'b1;
            end
         end
         SHAPE_RECTANGLE: begin
            if (sample < x0) flat = points[0].y;
            else if (sample > x3) flat = points[3].y;
            else if (sample >= x1) flat = points[1].y;
            else status = ST_RANGE;
         end
         SHAPE_SINGLETON: begin
            use_tol = 1'b0;
            if (sample == x0) flat = points[0].y;
         end
         default: begin
            status = ST_RANGE;
         end
      endcase
   end

   assign dx_w = {points[sel_b].x[COORD_WIDTH-1], points[sel_b].x}
               - {points[sel_a].x[COORD_WIDTH-1], points[sel_a].x};
   assign dv_w = {sample[SAMPLE_WIDTH-1], sample}
               - {points[sel_a].x[COORD_WIDTH-1], points[sel_a].x};
   assign dy_w = $signed({1'b0, points[sel_b].y}) - $signed({1'b0, points[sel_a].y});

   always_comb begin
      front_in.valid        = accept;
      front_in.side.neg     = 1'b0;
      front_in.side.status  = status;
      front_in.side.use_tol = use_tol;
      if (seg_en) begin
         front_in.dy        = dy_w;
         front_in.dv        = dv_w[COORD_WIDTH-1:0];
         front_in.den       = dx_w[COORD_WIDTH-1:0];
         front_in.side.base = points[sel_a].y;
      end else begin
         // Flat result: a zero numerator over one leaves the quotient at zero.
         front_in.dy        = '0;
         front_in.dv        = '0;
         front_in.den       = COORD_WIDTH'(1);
         front_in.side.base = flat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff.valid <= 1'b0;
      end else begin
         front_ff.valid <= front_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      front_ff.dy   <= front_in.dy;
      front_ff.dv   <= front_in.dv;
      front_ff.den  <= front_in.den;
      front_ff.side <= front_in.side;
   end

   assign front = front_ff;

endmodule

// File: rtl/fme_mul.sv
// Product stage: |dy| times the offset into the segment, loaded into a division lane.
`timescale 1ns / 1ps

module fme_mul import fme_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  front_type front,
   output lane_type  lane
);

   lane_type lane_ff;
   lane_type lane_in;

   logic signed [MEMBER_WIDTH:0]            dy_abs;
   logic [MEMBER_WIDTH+COORD_WIDTH-1:0]     prod;

   assign dy_abs = front.dy[MEMBER_WIDTH] ? -front.dy : front.dy;
   assign prod   = dy_abs[MEMBER_WIDTH-1:0] * front.dv;

   always_comb begin
      lane_in.valid    = front.valid;
      lane_in.part     = prod[MEMBER_WIDTH+COORD_WIDTH-1:MEMBER_WIDTH];
      lane_in.nq       = prod[MEMBER_WIDTH-1:0];
      lane_in.den      = front.den;
      lane_in.side     = front.side;
      lane_in.side.neg = front.dy[MEMBER_WIDTH];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff.valid <= 1'b0;
      end else begin
         lane_ff.valid <= lane_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      lane_ff.part <= lane_in.part;
      lane_ff.nq   <= lane_in.nq;
      lane_ff.den  <= lane_in.den;
      lane_ff.side <= lane_in.side;
   end

   assign lane = lane_ff;

endmodule

// File: rtl/fme_div_cell.sv
// One restoring-division cell: produces one quotient bit and hands the lane on.
`timescale 1ns / 1ps

module fme_div_cell import fme_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  lane_type lane_i,
   output lane_type lane_o
);

   lane_type lane_ff;
   lane_type lane_in;

   logic [COORD_WIDTH:0] trial;
   logic                 fits;
   logic [COORD_WIDTH:0] diff;

   // Bring down the next numerator bit and try the subtract.
   assign trial = {lane_i.part, lane_i.nq[MEMBER_WIDTH-1]};
   assign diff  = trial - {1'b0, lane_i.den};
   assign fits  = trial >= {1'b0, lane_i.den};

   always_comb begin
      lane_in       = lane_i;
      lane_in.part  = fits ? diff[COORD_WIDTH-1:0] : trial[COORD_WIDTH-1:0];
      lane_in.nq    = {lane_i.nq[MEMBER_WIDTH-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff.valid <= 1'b0;
      end else begin
         lane_ff.valid <= lane_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      lane_ff.part <= lane_in.part;
      lane_ff.nq   <= lane_in.nq;
      lane_ff.den  <= lane_in.den;
      lane_ff.side <= lane_in.side;
   end

   assign lane_o = lane_ff;

endmodule

// File: rtl/fme_finish.sv
// Output stage: applies the quotient, saturates, applies the tolerance, registers the result.
`timescale 1ns / 1ps

module fme_finish import fme_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  lane_type                lane,
   input  logic [MEMBER_WIDTH-1:0] tolerance,
   output logic                    valid,
   output logic [MEMBER_WIDTH-1:0] membership,
   output logic [1:0]              status
);

   logic                    valid_ff;
   logic [MEMBER_WIDTH-1:0] membership_ff;
   logic [1:0]              status_ff;
   logic [MEMBER_WIDTH-1:0] membership_in;

   logic signed [MEMBER_WIDTH+1:0] quot;
   logic signed [MEMBER_WIDTH+1:0] sum;
   logic [MEMBER_WIDTH-1:0]        sat;

   assign quot = $signed({2'b00, lane.nq});
   assign sum  = $signed({2'b00, lane.side.base}) + (lane.side.neg ? -quot : quot);

   always_comb begin
      if (sum[MEMBER_WIDTH+1]) begin
         sat = '0;
      end else if (sum > $signed({2'b00, MEMBER_ONE})) begin
         sat = MEMBER_ONE;
      end else begin
         sat = sum[MEMBER_WIDTH-1:0];
      end

      if (lane.side.status != ST_OK) begin
         membership_in = '0;
      end else if (lane.side.use_tol && (sat < tolerance)) begin
         membership_in = '0;
      end else begin
         membership_in = sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= lane.valid;
      end
   end

   always_ff @(posedge clock) begin
      membership_ff <= membership_in;
      status_ff     <= lane.side.status;
   end

   assign valid      = valid_ff;
   assign membership = membership_ff;
   assign status     = status_ff;

endmodule

// File: rtl/fuzzy_membership_evaluator.sv
// Top level of the fuzzy membership evaluator: registers, pipeline and division chain.
`timescale 1ns / 1ps

// Fuzzifier for one term (triangle, ramp, trapezoid, rectangle or singleton).
//
// Input: drive req_sample and raise start; the sample transfers at every
// rising edge where start is high and busy is low. busy is low whenever
// reset is low, so a new sample may transfer in every cycle.
//
// Result: rsp_valid strobes for exactly one cycle with rsp_membership
// (unsigned Q1.15, at most 1.0) and rsp_status (ok, point order error,
// undefined range). The receiver has no way to stall; results leave in the
// order samples arrived.
//
// The pipeline is one decode stage, one multiply stage, a chain of 16 division
// cells (one quotient bit each) and one output stage. Throughput is one sample
// per cycle.
//
// Configuration: csr_we / csr_index / csr_wdata write shape, the four points,
// and the zero tolerance; write them only while no sample is in flight.
// Reset clears the configuration registers to zero and empties the pipeline.

module fuzzy_membership_evaluator import fme_pkg::*; (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic signed [SAMPLE_WIDTH-1:0]  req_sample,
   output logic                            rsp_valid,
   output logic [MEMBER_WIDTH-1:0]         rsp_membership,
   output logic [1:0]                      rsp_status,
   input  logic                            csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0]      csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]       csr_wdata
);

   logic [2:0]                  shape_ff;
   point_type [POINT_COUNT-1:0] points_ff;
   logic [MEMBER_WIDTH-1:0]     tolerance_ff;

   logic      accept;
   front_type front;
   lane_type  lanes [0:DIV_STEPS];

   // Hold configuration; unknown indexes drop the write.
   always_ff @(posedge clock) begin
      if (reset) begin
         shape_ff     <= '0;
         points_ff    <= '0;
         tolerance_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SHAPE:        shape_ff     <= csr_wdata[2:0];
            CSR_POINT_FIRST:  points_ff[0] <= point_type'(csr_wdata);
            CSR_POINT_SECOND: points_ff[1] <= point_type'(csr_wdata);
            CSR_POINT_THIRD:  points_ff[2] <= point_type'(csr_wdata);
            CSR_POINT_FOURTH: points_ff[3] <= point_type'(csr_wdata);
            CSR_TOLERANCE:    tolerance_ff <= csr_wdata[MEMBER_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // The pipeline never backs up, so only reset refuses a transfer.
   assign busy   = reset;
   assign accept = start && !busy;

   fme_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .sample (req_sample),
      .shape  (shape_ff),
      .points (points_ff),
      .front  (front)
   );

   fme_mul u_mul (
      .clock (clock),
      .reset (reset),
      .front (front),
      .lane  (lanes[0])
   );

   // Advance each lane one cell per cycle; one quotient bit per cell.
   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
      fme_div_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .lane_i (lanes[i]),
         .lane_o (lanes[i+1])
      );
   end

   fme_finish u_finish (
      .clock      (clock),
      .reset      (reset),
      .lane       (lanes[DIV_STEPS]),
      .tolerance  (tolerance_ff),
      .valid      (rsp_valid),
      .membership (rsp_membership),
      .status     (rsp_status)
   );

endmodule

// File: bench/fme_membership_checker.sv
// Checker for the fuzzy membership evaluator: tracks registers, predicts and compares results.
`timescale 1ns / 1ps

module fme_membership_checker import fme_pkg::*; (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           busy,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   input  logic                           rsp_valid,
   input  logic [MEMBER_WIDTH-1:0]        rsp_membership,
   input  logic [1:0]                     rsp_status,
   input  logic                           csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]      csr_wdata,
   output int                             failures,
   output int                             pending
);

   typedef struct packed {
      logic [MEMBER_WIDTH-1:0] membership;
      status_type              status;
   } grade_type;

   logic [2:0]                shape_reg;
   logic [CSR_DATA_WIDTH-1:0] point_reg [POINT_COUNT];
   logic [MEMBER_WIDTH-1:0]   tolerance_reg;
   grade_type                 grades_due [$];

   initial begin
      failures = 0;
      pending  = 0;
   end

   // Straight line between two points, quotient truncated toward zero.
   function automatic longint lerp(longint xa, longint ya, longint xb, longint yb,
                                   longint v);
      return ya + ((yb - ya) * (v - xa)) / (xb - xa);
   endfunction

   function automatic grade_type grade_membership(logic signed [SAMPLE_WIDTH-1:0] sample);
      longint     v;
      longint     x [POINT_COUNT];
      longint     y [POINT_COUNT];
      longint     m;
      status_type st;
      bit         use_tol;
      grade_type  g;
      v = sample;
      for (int i = 0; i < POINT_COUNT; i++) begin
         x[i] = $signed(point_reg[i][CSR_DATA_WIDTH-1:MEMBER_WIDTH]);
         y[i] = point_reg[i][MEMBER_WIDTH-1:0];
      end
      m       = 0;
      st      = ST_OK;
      use_tol = 1'b1;
      case (shape_reg)
         SHAPE_TRIANGLE: begin
            if (v <= x[0]) m = y[0];
            else if (v >= x[2]) m = y[2];
            else if (v <= x[1]) begin
               if (x[1] <= x[0]) st = ST_ORDER;
               else m = lerp(x[0], y[0], x[1], y[1], v);
            end else begin
               if (x[2] <= x[1]) st = ST_ORDER;
               else m = lerp(x[1], y[1], x[2], y[2], v);
            end
         end
         SHAPE_RAMP: begin
            if (v <= x[0]) m = y[0];
            else if (v >= x[1]) m = y[1];
            else m = lerp(x[0], y[0], x[1], y[1], v);
         end
         SHAPE_TRAPEZOID: begin
            if (v <= x[0]) m = y[0];
            else if (v >= x[3]) m = y[3];
            else if (v <= x[1]) begin
               if (x[1] <= x[0]) st = ST_ORDER;
               else m = lerp(x[0], y[0], x[1], y[1], v);
            end else if (v <= x[2]) m = y[1];
            else begin
               if (x[3] <= x[2]) st = ST_ORDER;
               else m = lerp(x[2], y[2], x[3], y[3], v);
            end
         end
         SHAPE_RECTANGLE: begin
            if (v < x[0]) m = y[0];
            else if (v > x[3]) m = y[3];
            else if (v >= x[1]) m = y[1];
            else st = ST_RANGE;
         end
         SHAPE_SINGLETON: begin
            use_tol = 1'b0;
            m = (v == x[0]) ? y[0] : 0;
         end
         default: st = ST_RANGE;
      endcase
      if (st != ST_OK) m = 0;
      else begin
         if (m < 0) m = 0;
         if (m > MEMBER_ONE) m = MEMBER_ONE;
         if (use_tol && m < tolerance_reg) m = 0;
      end
      g.membership = m[MEMBER_WIDTH-1:0];
      g.status     = st;
      return g;
   endfunction

   always @(posedge clock) begin
      grade_type due;
      if (reset) begin
         shape_reg     = SHAPE_TRIANGLE;
         tolerance_reg = '0;
         for (int i = 0; i < POINT_COUNT; i++) point_reg[i] = '0;
         grades_due.delete();
      end else begin
         if (rsp_valid) begin
            if (grades_due.size() == 0) begin
               $error("rsp_valid: no result expected, got membership %0d status %0d",
                      rsp_membership, rsp_status);
               failures++;
            end else begin
               due = grades_due.pop_front();
               if (rsp_membership !== due.membership) begin
                  $error("membership: expected %0d, got %0d", due.membership, rsp_membership);
                  failures++;
               end
               if (rsp_status !== due.status) begin
                  $error("status: expected %0d, got %0d", due.status, rsp_status);
                  failures++;
               end
            end
         end
         // Predict before a register write of the same edge takes effect.
         if (start && !busy) grades_due.push_back(grade_membership(req_sample));
         if (csr_we) begin
            case (csr_index)
               CSR_SHAPE:        shape_reg     = csr_wdata[2:0];
               CSR_POINT_FIRST:  point_reg[0]  = csr_wdata;
               CSR_POINT_SECOND: point_reg[1]  = csr_wdata;
               CSR_POINT_THIRD:  point_reg[2]  = csr_wdata;
               CSR_POINT_FOURTH: point_reg[3]  = csr_wdata;
               CSR_TOLERANCE:    tolerance_reg = csr_wdata[MEMBER_WIDTH-1:0];
               default: ;
            endcase
         end
      end
      pending = grades_due.size();
   end

endmodule

// File: bench/fuzzy_membership_evaluator_tb.sv
// Testbench top of the fuzzy membership evaluator: stimulus, register phases and verdict.
`timescale 1ns / 1ps

module fuzzy_membership_evaluator_tb;
   import fme_pkg::*;

   // Shape codes past the singleton select no term; keep the last one by name.
   localparam logic [2:0] SHAPE_SPARE_LAST = 3'd7;
   localparam int         PHASES           = 20;
   localparam int         PHASE_ITEMS      = 100;
   localparam int         X_MIN            = -32768;
   localparam int         X_MAX            = 32767;

   logic                           clock;
   logic                           reset;
   logic                           start;
   logic                           busy;
   logic signed [SAMPLE_WIDTH-1:0] req_sample;
   logic                           rsp_valid;
   logic [MEMBER_WIDTH-1:0]        rsp_membership;
   logic [1:0]                     rsp_status;
   logic                           csr_we;
   logic [CSR_INDEX_WIDTH-1:0]     csr_index;
   logic [CSR_DATA_WIDTH-1:0]      csr_wdata;
   int                             failures;
   int                             pending;

   // Stimulus state.
   int                             burst_left;
   int                             xs [POINT_COUNT];
   int                             ys [POINT_COUNT];
   int                             mode;
   int                             pick;
   int                             lo;
   int                             hi;
   int                             value;
   int                             swap;
   logic [2:0]                     shape_code;
   logic [MEMBER_WIDTH-1:0]        tolerance;

   fuzzy_membership_evaluator i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_membership (rsp_membership),
      .rsp_status     (rsp_status),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   fme_membership_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_membership (rsp_membership),
      .rsp_status     (rsp_status),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .failures       (failures),
      .pending        (pending)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Stop a hung run; the slowest correct run needs well under a tenth of this.
   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   function automatic logic [CSR_DATA_WIDTH-1:0] pack_point(int x, int y);
      return {COORD_WIDTH'(x), MEMBER_WIDTH'(y)};
   endfunction

   // Write one register at a falling edge; the block takes it at the next rising edge.
   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_WIDTH-1:0] data);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we    = 1'b0;
   endtask

   // Offer one sample and hold it until it transfers. At the end of a burst drop start
   // for a random gap and drive noise on the sample port meanwhile.
   task automatic send_sample(logic signed [SAMPLE_WIDTH-1:0] sample);
      @(negedge clock);
      start      = 1'b1;
      req_sample = sample;
      do @(posedge clock); while (busy);
      burst_left--;
      if (burst_left <= 0) begin
         @(negedge clock);
         start      = 1'b0;
         req_sample = SAMPLE_WIDTH'($urandom);
         repeat ($urandom_range(0, 5)) @(negedge clock);
         // Mostly short bursts, now and then a long stretch with no gap at all.
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                   : $urandom_range(1, 6);
      end
   endtask

   // Wait until every transfer has its result, then let the pipeline settle.
   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      for (int n = 0; n < 400 && pending != 0; n++) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      reset      = 1'b1;
      start      = 1'b0;
      req_sample = '0;
      csr_we     = 1'b0;
      csr_index  = CSR_SHAPE;
      csr_wdata  = '0;
      burst_left = 3;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Registers at their reset values: a triangle collapsed onto zero.
      send_sample(16'sh8000);
      send_sample(16'sh7FFF);
      drain();

      // Symmetric triangle: clamps, both slopes, peak.
      write_reg(CSR_SHAPE, 32'(SHAPE_TRIANGLE));
      write_reg(CSR_POINT_FIRST, pack_point(-1000, 0));
      write_reg(CSR_POINT_SECOND, pack_point(0, 32768));
      write_reg(CSR_POINT_THIRD, pack_point(1000, 0));
      write_reg(CSR_TOLERANCE, 0);
      send_sample(-1000);
      send_sample(-999);
      send_sample(-1);
      send_sample(0);
      send_sample(500);
      send_sample(999);
      send_sample(32767);
      drain();

      // Falling ramp across the full axis with an oversized y and the top tolerance.
      write_reg(CSR_SHAPE, 32'(SHAPE_RAMP));
      write_reg(CSR_POINT_FIRST, pack_point(X_MIN, 65535));
      write_reg(CSR_POINT_SECOND, pack_point(X_MAX, 0));
      write_reg(CSR_TOLERANCE, 32768);
      send_sample(-32768);
      send_sample(0);
      drain();

      // Trapezoid with a flat top, then with the third point behind the second.
      write_reg(CSR_SHAPE, 32'(SHAPE_TRAPEZOID));
      write_reg(CSR_POINT_FIRST, pack_point(-2000, 0));
      write_reg(CSR_POINT_SECOND, pack_point(-1000, 30000));
      write_reg(CSR_POINT_THIRD, pack_point(1000, 0));
      write_reg(CSR_POINT_FOURTH, pack_point(2000, 100));
      write_reg(CSR_TOLERANCE, 0);
      send_sample(-1500);
      send_sample(0);
      send_sample(1500);
      send_sample(2000);
      drain();
      write_reg(CSR_POINT_THIRD, pack_point(-1500, 7000));
      send_sample(-500);
      drain();

      // Rectangle: below, the gap on both ends, top, above.
      write_reg(CSR_SHAPE, 32'(SHAPE_RECTANGLE));
      write_reg(CSR_POINT_FIRST, pack_point(-100, 3));
      write_reg(CSR_POINT_SECOND, pack_point(100, 20000));
      write_reg(CSR_POINT_FOURTH, pack_point(300, 5));
      send_sample(-101);
      send_sample(-100);
      send_sample(99);
      send_sample(100);
      send_sample(301);
      drain();

      // Singleton: oversized y saturates, a miss gives zero, tolerance is ignored.
      write_reg(CSR_SHAPE, 32'(SHAPE_SINGLETON));
      write_reg(CSR_POINT_FIRST, pack_point(5, 65535));
      write_reg(CSR_TOLERANCE, 32768);
      send_sample(5);
      send_sample(6);
      drain();
      write_reg(CSR_POINT_FIRST, pack_point(5, 10));
      send_sample(5);
      drain();

      // A shape code that selects no term.
      write_reg(CSR_SHAPE, 32'(SHAPE_SPARE_LAST));
      send_sample(0);
      drain();

      // Random phases: fresh registers each phase, then a stream of samples.
      for (int phase = 0; phase < PHASES; phase++) begin
         // Walk through every shape first, then pick at random with a few spare codes.
         if (phase < 10) shape_code = 3'(phase % 5);
         else if ($urandom_range(0, 11) == 0)
            shape_code = 3'($urandom_range(SHAPE_SINGLETON + 1, SHAPE_SPARE_LAST));
         else shape_code = 3'($urandom_range(SHAPE_TRIANGLE, SHAPE_SINGLETON));

         // Point layouts: wide sorted, narrow sorted, full-axis span, unsorted.
         mode = (phase < 4) ? phase : $urandom_range(0, 4);
         for (int i = 0; i < POINT_COUNT; i++) xs[i] = $signed(16'($urandom));
         if (mode == 1) begin
            xs[0] = $urandom_range(0, 65535) + X_MIN;
            for (int i = 1; i < POINT_COUNT; i++) begin
               xs[i] = xs[i-1] + $urandom_range(0, 300);
               if (xs[i] > X_MAX) xs[i] = X_MAX;
            end
         end else if (mode == 2) begin
            xs[0] = X_MIN;
            xs[3] = X_MAX;
         end
         if (mode != 3) begin
            for (int i = 0; i < POINT_COUNT - 1; i++)
               for (int j = 0; j < POINT_COUNT - 1 - i; j++)
                  if (xs[j] > xs[j+1]) begin
                     swap    = xs[j];
                     xs[j]   = xs[j+1];
                     xs[j+1] = swap;
                  end
         end
         for (int i = 0; i < POINT_COUNT; i++) begin
            case ($urandom_range(0, 6))
               0:       ys[i] = 0;
               1:       ys[i] = 32768;
               2:       ys[i] = 65535;
               3:       ys[i] = $urandom_range(0, 65535);
               default: ys[i] = $urandom_range(0, 32768);
            endcase
         end

         // Tolerance: both extremes first, then off, small or anywhere.
         if (phase == 0) tolerance = 16'd32768;
         else if (phase == 1) tolerance = '0;
         else begin
            case ($urandom_range(0, 2))
               0:       tolerance = '0;
               1:       tolerance = 16'($urandom_range(0, 2000));
               default: tolerance = 16'($urandom_range(0, 32768));
            endcase
         end

         write_reg(CSR_SHAPE, 32'(shape_code));
         write_reg(CSR_POINT_FIRST, pack_point(xs[0], ys[0]));
         write_reg(CSR_POINT_SECOND, pack_point(xs[1], ys[1]));
         write_reg(CSR_POINT_THIRD, pack_point(xs[2], ys[2]));
         write_reg(CSR_POINT_FOURTH, pack_point(xs[3], ys[3]));
         write_reg(CSR_TOLERANCE, 32'(tolerance));

         for (int k = 0; k < PHASE_ITEMS; k++) begin
            pick = $urandom_range(0, 3);
            if (pick == 1) begin
               // Hit a point exactly or just beside it.
               value = xs[$urandom_range(0, POINT_COUNT - 1)] + $urandom_range(0, 6) - 3;
            end else if (pick == 2) begin
               // Land between two neighboring points.
               swap  = $urandom_range(0, POINT_COUNT - 2);
               lo    = (xs[swap] < xs[swap+1]) ? xs[swap] : xs[swap+1];
               hi    = (xs[swap] < xs[swap+1]) ? xs[swap+1] : xs[swap];
               value = $urandom_range(lo - X_MIN, hi - X_MIN) + X_MIN;
            end else value = $signed(16'($urandom));
            if (value > X_MAX) value = X_MAX;
            if (value < X_MIN) value = X_MIN;
            send_sample(SAMPLE_WIDTH'(value));
         end
         drain();
      end

      // Hold past the pipeline latency so that a stray result still shows up.
      repeat (25) @(negedge clock);
      if (failures == 0 && pending == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule

// File: sim.f
rtl/fme_pkg.sv
rtl/fme_front.sv
rtl/fme_mul.sv
rtl/fme_div_cell.sv
rtl/fme_finish.sv
rtl/fuzzy_membership_evaluator.sv
bench/fme_membership_checker.sv
bench/fuzzy_membership_evaluator_tb.sv
